// ===== rtl/core/cgb_wram_pkg.sv =====
// Shared types, port codes and reset values for the work RAM and IO map.
`timescale 1ns / 1ps
`default_nettype none
package cgb_wram_pkg;

	// Region that an access falls in after the echo area is folded back.
	typedef enum logic [2:0] {
		RG_FAULT,
		RG_WRAM,
		RG_OAM,
		RG_UNUSED,
		RG_IO,
		RG_HRAM
	} region_t;

	// Where the result byte of an item comes from in the result cycle.
	typedef enum logic [2:0] {
		SRC_DIRECT,
		SRC_WRAM,
		SRC_OAM,
		SRC_HRAM,
		SRC_IO,
		SRC_BGPAL,
		SRC_OBJPAL
	} src_t;

	// Sequencer states.
	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} state_t;

	// Decoded access handed from the decoder to the top level.
	typedef struct packed {
		region_t    region;
		logic       bank_hi;
		logic [7:0] low;
	} dec_t;

	// IO port numbers.
	localparam logic [7:0] P_P1    = 8'h00;
	localparam logic [7:0] P_SC    = 8'h02;
	localparam logic [7:0] P_DIV   = 8'h04;
	localparam logic [7:0] P_TAC   = 8'h07;
	localparam logic [7:0] P_IF    = 8'h0F;
	localparam logic [7:0] P_LCDC  = 8'h40;
	localparam logic [7:0] P_STAT  = 8'h41;
	localparam logic [7:0] P_BGP   = 8'h47;
	localparam logic [7:0] P_VBK   = 8'h4F;
	localparam logic [7:0] P_HDMA5 = 8'h55;
	localparam logic [7:0] P_RP    = 8'h56;
	localparam logic [7:0] P_BCPS  = 8'h68;
	localparam logic [7:0] P_BCPD  = 8'h69;
	localparam logic [7:0] P_OCPS  = 8'h6A;
	localparam logic [7:0] P_OCPD  = 8'h6B;
	localparam logic [7:0] P_SVBK  = 8'h70;

	// Power-up values of registers held in flip-flops.
	localparam logic [7:0] P1_RESET   = 8'hCF;
	localparam logic [7:0] SVBK_RESET = 8'hF8;

	// Power-up value of an IO register kept in the IO memory.
	function automatic logic [7:0] io_reset_value(input logic [7:0] port);
		logic [7:0] v;
		case (port)
			P_SC:    v = 8'h7F;
			P_TAC:   v = 8'hF8;
			P_IF:    v = 8'hE1;
			P_LCDC:  v = 8'h91;
			P_BGP:   v = 8'hFC;
			P_RP:    v = 8'h3E;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cgb_wram_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module cgb_wram_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem [DEPTH];

	// Writes beyond the depth are dropped; the read is registered.
	always_ff @(posedge clk) begin
		if (we && ({1'b0, addr} < (AW+1)'(DEPTH))) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// ===== rtl/core/cgb_wram_dec.sv =====
// Address decoder: folds the echo area and classifies the bus address.
`timescale 1ns / 1ps
`default_nettype none
module cgb_wram_dec (
	input  wire logic [15:0]        address,
	output cgb_wram_pkg::dec_t      dec
);
	logic [15:0] ae;

	// Echo RAM maps back onto work RAM by clearing address bit 13.
	always_comb begin
		ae = address;
		if (address[15:13] == 3'b111 && address[15:9] != 7'h7F) begin
			ae[13] = 1'b0;
		end
	end

	// Classify the folded address into one region.
	always_comb begin
		dec.bank_hi = ae[12];
		dec.low     = ae[7:0];
		priority if (ae[15:14] != 2'b11) begin
			dec.region = cgb_wram_pkg::RG_FAULT;
		end else if (ae[15:13] == 3'b110) begin
			dec.region = cgb_wram_pkg::RG_WRAM;
		end else if (ae[15:8] == 8'hFE && ae[7:0] < 8'hA0) begin
			dec.region = cgb_wram_pkg::RG_OAM;
		end else if (ae[15:8] == 8'hFE) begin
			dec.region = cgb_wram_pkg::RG_UNUSED;
		end else if (!ae[7] || ae[7:0] == 8'hFF) begin
			dec.region = cgb_wram_pkg::RG_IO;
		end else begin
			dec.region = cgb_wram_pkg::RG_HRAM;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/cgb_work_ram_and_io_map_top.sv =====
// Top level of the work RAM and IO map: sequencer, memories and IO side effects.
`timescale 1ns / 1ps
`default_nettype none
// An item is taken when start is high and busy is low. The next cycle performs
// the memory access, and the result appears with done for one cycle after that.
// Busy is high while an item is in the access stage, so no new item is taken
// until it has moved on. After reset, busy stays high while one clearing pass
// writes every work RAM entry and the power-up contents of OAM, high RAM, IO
// and palette memories.
// The receiver cannot stall: each result must be taken in its done cycle.
module cgb_work_ram_and_io_map_top #(
	parameter int WRAM_BANKS = 8,
	parameter int BANK_BYTES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        mode,
	input  wire logic [15:0] address,
	input  wire logic [7:0]  write_byte,
	output logic [7:0]       read_byte,
	output logic             fault,
	output logic             done
);
	localparam int WDEPTH = WRAM_BANKS * BANK_BYTES;
	localparam int WAW    = $clog2(WDEPTH);
	localparam int OFF_W  = $clog2(BANK_BYTES);
	localparam int BW     = WAW - OFF_W;

	cgb_wram_pkg::state_t state_q, state_d;
	logic             clearing;
	logic [WAW-1:0]   clr_q;

	logic             v_s1;
	logic             mode_s1;
	logic [15:0]      addr_s1;
	logic [7:0]       wdata_s1;
	cgb_wram_pkg::dec_t dec;

	logic             v_s2;
	cgb_wram_pkg::src_t src_s2, src_d;
	logic [7:0]       direct_s2, direct_d;
	logic             fault_s2, fault_d;

	logic [7:0]       p1_q, stat_q, svbk_q, bcps_q, ocps_q;
	logic             vbk_q;

	logic [2:0]       bank;
	logic [WAW-1:0]   wram_addr;
	logic [7:0]       io_wval;

	logic             wram_we, oam_we, hram_we, io_we, bg_we, obj_we;
	logic [WAW-1:0]   wram_a;
	logic [7:0]       oam_a, io_a;
	logic [6:0]       hram_a;
	logic [5:0]       bg_a, obj_a;
	logic [7:0]       wram_wd, oam_wd, hram_wd, io_wd, bg_wd, obj_wd;
	logic [7:0]       wram_rd, oam_rd, hram_rd, io_rd, bg_rd, obj_rd;

	logic             acc_wr, io_wr;

	// Sequencer: next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cgb_wram_pkg::ST_CLEAR: begin
				if (clr_q == WAW'(WDEPTH - 1)) begin
					state_d = cgb_wram_pkg::ST_RUN;
				end
			end
			cgb_wram_pkg::ST_RUN: state_d = cgb_wram_pkg::ST_RUN;
		endcase
	end

	// Sequencer: outputs.
	always_comb begin
		unique case (state_q)
			cgb_wram_pkg::ST_CLEAR: clearing = 1'b1;
			cgb_wram_pkg::ST_RUN:   clearing = 1'b0;
		endcase
		busy = clearing | v_s1;
	end

	// State register and clearing counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cgb_wram_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_q <= clr_q + WAW'(1);
			end
		end
	end

	// Input stage: capture an accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mode_s1  <= mode;
			addr_s1  <= address;
			wdata_s1 <= write_byte;
		end
	end

	cgb_wram_dec u_dec (
		.address (addr_s1),
		.dec     (dec)
	);

	// Bank select: zero means one, folded modulo the number of banks.
	always_comb begin
		bank = (svbk_q[2:0] == 3'd0) ? 3'd1 : svbk_q[2:0];
		for (int i = 0; i < 3; i++) begin
			if ({29'd0, bank} >= WRAM_BANKS) begin
				bank = bank - 3'(WRAM_BANKS);
			end
		end
		if (dec.bank_hi) begin
			wram_addr = {bank[BW-1:0], addr_s1[OFF_W-1:0]};
		end else begin
			wram_addr = {{BW{1'b0}}, addr_s1[OFF_W-1:0]};
		end
	end

	// Value that an IO write actually stores.
	always_comb begin
		unique case (dec.low)
			cgb_wram_pkg::P_DIV:   io_wval = 8'h00;
			cgb_wram_pkg::P_P1: begin
				if (wdata_s1[5:4] == 2'b11) begin
					io_wval = wdata_s1 | 8'h0F;
				end else begin
					io_wval = {wdata_s1[7:4], p1_q[3:0]};
				end
			end
			cgb_wram_pkg::P_VBK:   io_wval = {7'd0, wdata_s1[0]};
			cgb_wram_pkg::P_HDMA5: io_wval = 8'hFF;
			default:               io_wval = wdata_s1;
		endcase
	end

	assign acc_wr = v_s1 && mode_s1;
	assign io_wr  = acc_wr && dec.region == cgb_wram_pkg::RG_IO;

	// Memory ports: the clearing pass owns them until it ends.
	always_comb begin
		wram_we = clearing | (acc_wr && dec.region == cgb_wram_pkg::RG_WRAM);
		oam_we  = clearing | (acc_wr && dec.region == cgb_wram_pkg::RG_OAM);
		hram_we = clearing | (acc_wr && dec.region == cgb_wram_pkg::RG_HRAM);
		io_we   = clearing | io_wr;
		bg_we   = clearing | (io_wr && dec.low == cgb_wram_pkg::P_BCPD);
		obj_we  = clearing | (io_wr && dec.low == cgb_wram_pkg::P_OCPD);
		wram_a  = clearing ? clr_q : wram_addr;
		oam_a   = clearing ? clr_q[7:0] : dec.low;
		hram_a  = clearing ? clr_q[6:0] : dec.low[6:0];
		io_a    = clearing ? clr_q[7:0] : dec.low;
		bg_a    = clearing ? clr_q[5:0] : bcps_q[5:0];
		obj_a   = clearing ? clr_q[5:0] : ocps_q[5:0];
		wram_wd = clearing ? 8'h00 : wdata_s1;
		oam_wd  = clearing ? 8'h00 : wdata_s1;
		hram_wd = clearing ? 8'h00 : wdata_s1;
		io_wd   = clearing ? cgb_wram_pkg::io_reset_value(clr_q[7:0]) : io_wval;
		bg_wd   = clearing ? 8'h00 : wdata_s1;
		obj_wd  = clearing ? 8'h00 : wdata_s1;
	end

	cgb_wram_ram #(.WIDTH(8), .DEPTH(WDEPTH)) u_wram (
		.clk(clk), .we(wram_we), .addr(wram_a), .wdata(wram_wd), .rdata(wram_rd)
	);
	cgb_wram_ram #(.WIDTH(8), .DEPTH(160)) u_oam (
		.clk(clk), .we(oam_we), .addr(oam_a), .wdata(oam_wd), .rdata(oam_rd)
	);
	cgb_wram_ram #(.WIDTH(8), .DEPTH(128)) u_hram (
		.clk(clk), .we(hram_we), .addr(hram_a), .wdata(hram_wd), .rdata(hram_rd)
	);
	cgb_wram_ram #(.WIDTH(8), .DEPTH(256)) u_io (
		.clk(clk), .we(io_we), .addr(io_a), .wdata(io_wd), .rdata(io_rd)
	);
	cgb_wram_ram #(.WIDTH(8), .DEPTH(64)) u_bgpal (
		.clk(clk), .we(bg_we), .addr(bg_a), .wdata(bg_wd), .rdata(bg_rd)
	);
	cgb_wram_ram #(.WIDTH(8), .DEPTH(64)) u_objpal (
		.clk(clk), .we(obj_we), .addr(obj_a), .wdata(obj_wd), .rdata(obj_rd)
	);

	// Result source for the access stage.
	always_comb begin
		src_d    = cgb_wram_pkg::SRC_DIRECT;
		direct_d = 8'h00;
		fault_d  = 1'b0;
		unique case (dec.region)
			cgb_wram_pkg::RG_FAULT: fault_d = 1'b1;
			cgb_wram_pkg::RG_WRAM: begin
				if (mode_s1) direct_d = wdata_s1;
				else src_d = cgb_wram_pkg::SRC_WRAM;
			end
			cgb_wram_pkg::RG_OAM: begin
				if (mode_s1) direct_d = wdata_s1;
				else src_d = cgb_wram_pkg::SRC_OAM;
			end
			cgb_wram_pkg::RG_HRAM: begin
				if (mode_s1) direct_d = wdata_s1;
				else src_d = cgb_wram_pkg::SRC_HRAM;
			end
			cgb_wram_pkg::RG_UNUSED: begin
				if (mode_s1) direct_d = 8'h00;
				else if (stat_q[1]) direct_d = 8'hFF;
				else direct_d = {addr_s1[7:4], addr_s1[7:4]};
			end
			cgb_wram_pkg::RG_IO: begin
				if (mode_s1) begin
					direct_d = io_wval;
				end else begin
					unique case (dec.low)
						cgb_wram_pkg::P_BCPD: src_d = cgb_wram_pkg::SRC_BGPAL;
						cgb_wram_pkg::P_OCPD: src_d = cgb_wram_pkg::SRC_OBJPAL;
						cgb_wram_pkg::P_VBK:  direct_d = {7'h7F, vbk_q};
						cgb_wram_pkg::P_P1:   direct_d = p1_q;
						cgb_wram_pkg::P_STAT: direct_d = stat_q;
						cgb_wram_pkg::P_SVBK: direct_d = svbk_q;
						cgb_wram_pkg::P_BCPS: direct_d = bcps_q;
						cgb_wram_pkg::P_OCPS: direct_d = ocps_q;
						default:              src_d = cgb_wram_pkg::SRC_IO;
					endcase
				end
			end
			default: fault_d = 1'b1;
		endcase
	end

	// IO registers that the map itself reads are held in flip-flops.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1_q   <= cgb_wram_pkg::P1_RESET;
			stat_q <= 8'h00;
			svbk_q <= cgb_wram_pkg::SVBK_RESET;
			bcps_q <= 8'h00;
			ocps_q <= 8'h00;
			vbk_q  <= 1'b0;
		end else if (io_wr) begin
			unique case (dec.low)
				cgb_wram_pkg::P_P1:   p1_q   <= io_wval;
				cgb_wram_pkg::P_STAT: stat_q <= io_wval;
				cgb_wram_pkg::P_SVBK: svbk_q <= io_wval;
				cgb_wram_pkg::P_BCPS: bcps_q <= io_wval;
				cgb_wram_pkg::P_OCPS: ocps_q <= io_wval;
				cgb_wram_pkg::P_VBK:  vbk_q  <= io_wval[0];
				cgb_wram_pkg::P_BCPD: begin
					if (bcps_q[7]) bcps_q <= {2'b10, bcps_q[5:0] + 6'd1};
				end
				cgb_wram_pkg::P_OCPD: begin
					if (ocps_q[7]) ocps_q <= {2'b10, ocps_q[5:0] + 6'd1};
				end
				default: ;
			endcase
		end
	end

	// Result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			src_s2    <= src_d;
			direct_s2 <= direct_d;
			fault_s2  <= fault_d;
		end
	end

	// Result byte: memory read data arrives in this cycle.
	always_comb begin
		unique case (src_s2)
			cgb_wram_pkg::SRC_WRAM:   read_byte = wram_rd;
			cgb_wram_pkg::SRC_OAM:    read_byte = oam_rd;
			cgb_wram_pkg::SRC_HRAM:   read_byte = hram_rd;
			cgb_wram_pkg::SRC_IO:     read_byte = io_rd;
			cgb_wram_pkg::SRC_BGPAL:  read_byte = bg_rd;
			cgb_wram_pkg::SRC_OBJPAL: read_byte = obj_rd;
			default:                  read_byte = direct_s2;
		endcase
	end

	assign done  = v_s2;
	assign fault = fault_s2;

	// An accepted item reaches the access stage in the next cycle.
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> v_s1) else $error("accepted item not staged");

	// Every access stage is followed by exactly one result strobe.
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |=> done) else $error("result strobe missing");

	// No item is in flight while the clearing pass owns the memories.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !v_s1) else $error("item during clearing pass");

	// A faulting access reads as zero.
	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		done && fault |-> read_byte == 8'h00) else $error("fault with data");
endmodule
`default_nettype wire

// ===== test/cgb_map_checker.sv =====
// Checker that predicts and compares every access result of the work RAM and IO map.
`timescale 1ns / 1ps
`default_nettype none
module cgb_map_checker #(
	parameter int WRAM_BANKS = 8,
	parameter int BANK_BYTES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic        mode,
	input  wire logic [15:0] address,
	input  wire logic [7:0]  write_byte,
	input  wire logic [7:0]  read_byte,
	input  wire logic        fault,
	input  wire logic        done,
	output int               fail_count,
	output int               pending
);
	localparam int WRAM_SIZE = WRAM_BANKS * BANK_BYTES;

	typedef struct {
		logic [7:0] data;
		logic       flt;
	} access_result_t;

	logic [7:0] wram_m [WRAM_SIZE];
	logic [7:0] hram_m [127];
	logic [7:0] oam_m [160];
	logic [7:0] io_m [256];
	logic [7:0] bgpal_m [64];
	logic [7:0] objpal_m [64];
	access_result_t result_q [$];

	assign pending = result_q.size();

	// Power-up contents of every store.
	task automatic power_up();
		foreach (wram_m[i]) wram_m[i] = 8'h00;
		foreach (hram_m[i]) hram_m[i] = 8'h00;
		foreach (oam_m[i]) oam_m[i] = 8'h00;
		foreach (bgpal_m[i]) bgpal_m[i] = 8'h00;
		foreach (objpal_m[i]) objpal_m[i] = 8'h00;
		foreach (io_m[i]) io_m[i] = 8'h00;
		io_m[cgb_wram_pkg::P_TAC] = 8'hF8;
		io_m[cgb_wram_pkg::P_SC] = 8'h7F;
		io_m[cgb_wram_pkg::P_IF] = 8'hE1;
		io_m[cgb_wram_pkg::P_LCDC] = 8'h91;
		io_m[cgb_wram_pkg::P_BGP] = 8'hFC;
		io_m[cgb_wram_pkg::P_VBK] = 8'hFE;
		io_m[cgb_wram_pkg::P_RP] = 8'h3E;
		io_m[cgb_wram_pkg::P_SVBK] = 8'hF8;
		io_m[cgb_wram_pkg::P_P1] = 8'hCF;
	endtask

	// Store a palette byte and advance the index port when its auto-increment bit is set.
	function automatic void palette_store(input logic [7:0] idx_port, input logic [7:0] d,
			input logic is_bg);
		logic [7:0] idx;
		idx = io_m[idx_port];
		if (is_bg)
			bgpal_m[idx[5:0]] = d;
		else
			objpal_m[idx[5:0]] = d;
		if (idx[7])
			io_m[idx_port] = {2'b10, idx[5:0] + 6'd1};
	endfunction

	// Decode one access against the map and update the stores.
	function automatic access_result_t bus_access(input logic wr, input logic [15:0] a_in,
			input logic [7:0] d_in);
		access_result_t r;
		int unsigned a, idx, bank;
		logic [7:0] port, d;
		r.data = 8'h00;
		r.flt = 1'b0;
		a = a_in;
		d = d_in;
		if (a >= 'hE000 && a <= 'hFDFF)
			a -= 'h2000;
		if (a < 'hC000) begin
			r.flt = 1'b1;
		end else if (a <= 'hDFFF) begin
			if (a < 'hD000) begin
				idx = (a & 'hFFF) % WRAM_SIZE;
			end else begin
				bank = io_m[cgb_wram_pkg::P_SVBK] & 7;
				if (bank == 0)
					bank = 1;
				idx = (bank * BANK_BYTES + (a & 'hFFF)) % WRAM_SIZE;
			end
			if (wr)
				wram_m[idx] = d;
			r.data = wram_m[idx];
		end else if (a <= 'hFE9F) begin
			if (wr)
				oam_m[a - 'hFE00] = d;
			r.data = oam_m[a - 'hFE00];
		end else if (a <= 'hFEFF) begin
			if (!wr) begin
				if (io_m[cgb_wram_pkg::P_STAT][1])
					r.data = 8'hFF;
				else
					r.data = {a_in[7:4], a_in[7:4]};
			end
		end else if (a <= 'hFF7F || a == 'hFFFF) begin
			port = a_in[7:0];
			if (wr) begin
				case (port)
					cgb_wram_pkg::P_DIV: d = 8'h00;
					cgb_wram_pkg::P_P1: begin
						if (d[5:4] == 2'b11)
							d = d | 8'h0F;
						else
							d = {d[7:4], io_m[cgb_wram_pkg::P_P1][3:0]};
					end
					cgb_wram_pkg::P_BCPD: palette_store(cgb_wram_pkg::P_BCPS, d, 1'b1);
					cgb_wram_pkg::P_OCPD: palette_store(cgb_wram_pkg::P_OCPS, d, 1'b0);
					cgb_wram_pkg::P_VBK: d = d & 8'h01;
					cgb_wram_pkg::P_HDMA5: d = 8'hFF;
					default: ;
				endcase
				io_m[port] = d;
				r.data = d;
			end else begin
				case (port)
					cgb_wram_pkg::P_BCPD:
						r.data = bgpal_m[io_m[cgb_wram_pkg::P_BCPS][5:0]];
					cgb_wram_pkg::P_OCPD:
						r.data = objpal_m[io_m[cgb_wram_pkg::P_OCPS][5:0]];
					cgb_wram_pkg::P_VBK: r.data = io_m[cgb_wram_pkg::P_VBK] | 8'hFE;
					default: r.data = io_m[port];
				endcase
			end
		end else begin
			if (wr)
				hram_m[a - 'hFF80] = d;
			r.data = hram_m[a - 'hFF80];
		end
		return r;
	endfunction

	initial begin
		fail_count = 0;
		power_up();
	end

	// Queue a prediction for each accepted item and compare each result.
	always @(posedge clk) begin
		access_result_t want;
		if (arst_n) begin
			if (done) begin
				if (result_q.size() == 0) begin
					$display("%0t: unexpected result read_byte=%h fault=%b",
						$time, read_byte, fault);
					fail_count++;
				end else begin
					want = result_q.pop_front();
					if (read_byte !== want.data) begin
						$display("%0t: read_byte expected %h actual %h",
							$time, want.data, read_byte);
						fail_count++;
					end
					if (fault !== want.flt) begin
						$display("%0t: fault expected %b actual %b",
							$time, want.flt, fault);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				result_q.push_back(bus_access(mode, address, write_byte));
		end
	end
endmodule
`default_nettype wire

// ===== test/tb_cgb_work_ram_and_io_map_top.sv =====
// Testbench top: drives CPU bus accesses into the map and gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_cgb_work_ram_and_io_map_top;
	localparam int WRAM_BANKS = 8;
	localparam int BANK_BYTES = 4096;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        mode = 1'b0;
	logic [15:0] address = 16'h0000;
	logic [7:0]  write_byte = 8'h00;
	logic        busy, fault, done;
	logic [7:0]  read_byte;
	int          fail_count, pending;
	int          cycles = 0;

	cgb_work_ram_and_io_map_top #(.WRAM_BANKS(WRAM_BANKS), .BANK_BYTES(BANK_BYTES)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.address(address), .write_byte(write_byte), .read_byte(read_byte),
		.fault(fault), .done(done)
	);

	cgb_map_checker #(.WRAM_BANKS(WRAM_BANKS), .BANK_BYTES(BANK_BYTES)) checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.address(address), .write_byte(write_byte), .read_byte(read_byte),
		.fault(fault), .done(done), .fail_count(fail_count), .pending(pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Present one item and hold it until the block takes it; start stays high after.
	task automatic issue(input logic wr, input logic [15:0] a, input logic [7:0] d);
		start <= 1'b1;
		mode <= wr;
		address <= a;
		write_byte <= d;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// Drop start for a random gap, mostly short.
	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// Random address weighted toward the mapped regions and IO side effects.
	function automatic logic [15:0] pick_address();
		logic [7:0] ports [10];
		ports = '{cgb_wram_pkg::P_P1, cgb_wram_pkg::P_DIV, cgb_wram_pkg::P_VBK,
			cgb_wram_pkg::P_HDMA5, cgb_wram_pkg::P_BCPS, cgb_wram_pkg::P_BCPD,
			cgb_wram_pkg::P_OCPS, cgb_wram_pkg::P_OCPD, cgb_wram_pkg::P_SVBK,
			cgb_wram_pkg::P_STAT};
		case ($urandom_range(0, 9))
			0: return 16'($urandom_range(0, 'hBFFF));
			1, 2: return 16'($urandom_range('hC000, 'hDFFF));
			3: return 16'($urandom_range('hE000, 'hFDFF));
			4: return 16'($urandom_range('hFE00, 'hFEFF));
			5: return 16'($urandom_range('hFF00, 'hFF7F));
			6, 7: return {8'hFF, ports[$urandom_range(0, 9)]};
			default: return 16'($urandom_range('hFF80, 'hFFFF));
		endcase
	endfunction

	initial begin
		logic [15:0] a;
		logic [7:0] d;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: map edges, special registers and palette auto-increment.
		issue(1'b0, 16'h0000, 8'h00);
		issue(1'b1, 16'hBFFF, 8'hFF);
		issue(1'b1, 16'hC000, 8'hA5);
		issue(1'b0, 16'hE000, 8'h00);
		issue(1'b1, 16'hDFFF, 8'h5A);
		issue(1'b0, 16'hFDFF, 8'h00);
		issue(1'b1, 16'hFF70, 8'h00);
		issue(1'b1, 16'hD123, 8'h11);
		issue(1'b1, 16'hFF70, 8'hFF);
		issue(1'b0, 16'hD123, 8'h00);
		issue(1'b1, 16'hFE9F, 8'h77);
		issue(1'b0, 16'hFEA0, 8'h00);
		issue(1'b1, 16'hFF41, 8'h03);
		issue(1'b0, 16'hFEF0, 8'h00);
		issue(1'b1, 16'hFEC0, 8'h12);
		issue(1'b1, 16'hFF04, 8'hAB);
		issue(1'b1, 16'hFF00, 8'h20);
		issue(1'b1, 16'hFF00, 8'h30);
		issue(1'b0, 16'hFF4F, 8'h00);
		issue(1'b1, 16'hFF55, 8'h01);
		issue(1'b1, 16'hFF68, 8'hBF);
		issue(1'b1, 16'hFF69, 8'hC3);
		issue(1'b1, 16'hFF69, 8'h3C);
		issue(1'b0, 16'hFF69, 8'h00);
		issue(1'b1, 16'hFFFF, 8'h1F);
		issue(1'b0, 16'hFFFE, 8'h00);

		// Hold off until every result has come back.
		start <= 1'b0;
		while (pending != 0) @(negedge clk);

		// Random traffic with gaps.
		repeat (1550) begin
			a = pick_address();
			d = 8'($urandom());
			issue(1'($urandom()), a, d);
			if ($urandom_range(0, 2) == 0)
				idle_gap();
		end
		start <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire
